### hw/rtl/llf_pkg.sv
// Shared types, register indexes and saturating Q31 helpers for the ladder low-pass filter.
package llf_pkg;

   localparam int SampleWidth = 32;
   localparam int CoeffWidth  = 31;
   localparam int ShiftWidth  = 4;
   localparam int CsrIdxWidth = 2;

   typedef logic signed [SampleWidth-1:0] sample_type;
   typedef logic [CoeffWidth-1:0]         coeff_type;

   // CSR indexes
   localparam logic [CsrIdxWidth-1:0] CSR_CUTOFF_COEFF   = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_FEEDBACK_GAIN  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_FEEDBACK_SHIFT = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_OVERSAMPLE_ON  = 2'd3;

   localparam coeff_type FEEDBACK_GAIN_RESET = 31'h7FFF_FFFF;

   // clamp a wide signed value to the Q31 range
   function automatic sample_type q_sat(input logic signed [63:0] v);
      sample_type r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // arithmetic halving (floor)
   function automatic sample_type q_half(input sample_type a);
      return a >>> 1;
   endfunction

   // shift by (2 - sh): saturating left for sh <= 2, arithmetic right otherwise
   function automatic sample_type q_shl(input sample_type a, input logic [ShiftWidth-1:0] sh);
      logic signed [63:0] wide;
      logic [ShiftWidth-1:0] rsh;
      sample_type r;
      wide = {{32{a[31]}}, a};
      rsh  = sh - 4'd2;
      if (sh <= 4'd2) begin
         r = q_sat(wide <<< (4'd2 - sh));
      end else begin
         r = a >>> rsh;
      end
      return r;
   endfunction

endpackage

### hw/rtl/llf_qmul.sv
// Shared Q31 multiplier: registered product, then (a*b)>>31 with saturation.
module llf_qmul (
   input  logic                clock,
   input  llf_pkg::sample_type mul_a,
   input  llf_pkg::sample_type mul_b,
   output llf_pkg::sample_type mul_q
);

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;

   assign prod_in = mul_a * mul_b;

   // product register
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_q = llf_pkg::q_sat(prod_ff >>> 31);

endmodule

### hw/rtl/ladder_lowpass_filter_q31_unit.sv
// Top level of the four-pole ladder low-pass filter on signed Q31 samples.
// Four one-pole stages with resonance feedback, all in saturating Q31, computed by a small
// sequencer around one saturating adder, one shifter and one registered 32x32 multiplier.
// One filter update runs feedback sum, feedback multiply, feedback shift and stage-0 sum,
// then subtract, multiply and accumulate for each of the four stages.
// A sample without oversampling goes from accept to result register through the accept
// cycle, one update and the output cycle; with oversampling on it adds a midpoint cycle and
// runs two updates with the first-half output cycle between them. The next sample is accepted
// in the cycle after the result is registered, so a new sample is taken only once the last one
// is done, later if the result side stalls. The stage values run
// through a four-register ring that rotates once per stage, so every tap is fixed.
module ladder_lowpass_filter_q31_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // input samples
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [31:0]                   req_sample_in,
   // filtered samples
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [31:0]                   rsp_sample_out,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [llf_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [31:0]                          csr_data
);

   // sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MID    = 4'd1;
   localparam logic [3:0] ST_FB_ADD = 4'd2;
   localparam logic [3:0] ST_FB_MUL = 4'd3;
   localparam logic [3:0] ST_FB_SHL = 4'd4;
   localparam logic [3:0] ST_S0_ADD = 4'd5;
   localparam logic [3:0] ST_DIFF   = 4'd6;
   localparam logic [3:0] ST_MUL    = 4'd7;
   localparam logic [3:0] ST_UPD    = 4'd8;
   localparam logic [3:0] ST_FIN    = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [1:0]          stage_idx_ff, stage_idx_in;
   logic                pass_ff, pass_in;
   llf_pkg::sample_type x_ff, x_in;
   llf_pkg::sample_type x_cur_ff, x_cur_in;
   llf_pkg::sample_type acc_ff, acc_in;
   llf_pkg::sample_type y_ff, y_in;
   llf_pkg::sample_type ring_ff [4];
   llf_pkg::sample_type ring_in [4];
   llf_pkg::sample_type prev_final_ff, prev_final_in;
   llf_pkg::sample_type prev_input_ff, prev_input_in;
   logic                rsp_valid_ff, rsp_valid_in;
   llf_pkg::sample_type rsp_data_ff, rsp_data_in;

   llf_pkg::coeff_type                  cutoff_ff;
   llf_pkg::coeff_type                  gain_ff;
   logic [llf_pkg::ShiftWidth-1:0]      fb_shift_ff;
   logic                                oversample_ff;

   llf_pkg::sample_type alu_a, alu_b, alu_q;
   logic                alu_sub;
   logic signed [32:0]  alu_sum;
   llf_pkg::sample_type mul_a, mul_b, mul_q;
   llf_pkg::sample_type shl_q;
   logic                out_free;

   assign req_ready      = (state_ff == ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;
   assign out_free       = !rsp_valid_ff || rsp_ready;

   // shared multiplier
   llf_qmul u_qmul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_q (mul_q)
   );

   assign mul_a = (state_ff == ST_FB_MUL) ? {1'b0, gain_ff} : {1'b0, cutoff_ff};
   assign mul_b = acc_ff;

   // feedback shifter
   assign shl_q = llf_pkg::q_shl(mul_q, fb_shift_ff);

   // shared saturating adder: operand select per state
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         ST_MID: begin
            alu_a = llf_pkg::q_half(x_ff);
            alu_b = llf_pkg::q_half(prev_input_ff);
         end
         ST_FB_ADD: begin
            alu_a = llf_pkg::q_half(ring_ff[3]);
            alu_b = llf_pkg::q_half(prev_final_ff);
         end
         ST_S0_ADD: begin
            alu_a = acc_ff;
            alu_b = ring_ff[0];
         end
         ST_DIFF: begin
            // stage 0 takes input minus (feedback + own value), later stages the previous output
            alu_a   = (stage_idx_ff == 2'd0) ? x_cur_ff : ring_ff[3];
            alu_b   = (stage_idx_ff == 2'd0) ? acc_ff : ring_ff[0];
            alu_sub = 1'b1;
         end
         ST_UPD: begin
            alu_a = ring_ff[0];
            alu_b = mul_q;
         end
         ST_FIN: begin
            if (!oversample_ff) begin
               alu_a = ring_ff[3];
            end else if (!pass_ff) begin
               alu_a = llf_pkg::q_half(ring_ff[3]);
            end else begin
               alu_a = y_ff;
               alu_b = llf_pkg::q_half(ring_ff[3]);
            end
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   assign alu_sum = alu_sub ? ({alu_a[31], alu_a} - {alu_b[31], alu_b})
                            : ({alu_a[31], alu_a} + {alu_b[31], alu_b});
   assign alu_q   = llf_pkg::q_sat({{31{alu_sum[32]}}, alu_sum});

   // sequencer
   always_comb begin
      state_in      = state_ff;
      stage_idx_in  = stage_idx_ff;
      pass_in       = pass_ff;
      x_in          = x_ff;
      x_cur_in      = x_cur_ff;
      acc_in        = acc_ff;
      y_in          = y_ff;
      ring_in       = ring_ff;
      prev_final_in = prev_final_ff;
      prev_input_in = prev_input_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in     = req_sample_in;
               x_cur_in = req_sample_in;
               pass_in  = 1'b0;
               state_in = oversample_ff ? ST_MID : ST_FB_ADD;
            end
         end
         ST_MID: begin
            x_cur_in      = alu_q;
            prev_input_in = x_ff;
            state_in      = ST_FB_ADD;
         end
         ST_FB_ADD: begin
            acc_in   = alu_q;
            state_in = ST_FB_MUL;
         end
         ST_FB_MUL: begin
            state_in = ST_FB_SHL;
         end
         ST_FB_SHL: begin
            acc_in   = shl_q;
            state_in = ST_S0_ADD;
         end
         ST_S0_ADD: begin
            acc_in       = alu_q;
            stage_idx_in = 2'd0;
            state_in     = ST_DIFF;
         end
         ST_DIFF: begin
            acc_in   = alu_q;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            // rotate the ring: updated stage lands at the tail
            if (stage_idx_ff == 2'd0) begin
               prev_final_in = ring_ff[3];
            end
            ring_in[0]   = ring_ff[1];
            ring_in[1]   = ring_ff[2];
            ring_in[2]   = ring_ff[3];
            ring_in[3]   = alu_q;
            stage_idx_in = stage_idx_ff + 2'd1;
            state_in     = (stage_idx_ff == 2'd3) ? ST_FIN : ST_DIFF;
         end
         ST_FIN: begin
            if (oversample_ff && !pass_ff) begin
               // first half done: run again on the current sample
               y_in     = alu_q;
               x_cur_in = x_ff;
               pass_in  = 1'b1;
               state_in = ST_FB_ADD;
            end else if (out_free) begin
               rsp_data_in  = alu_q;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         stage_idx_ff  <= 2'd0;
         pass_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         ring_ff       <= '{default: '0};
         prev_final_ff <= '0;
         prev_input_ff <= '0;
      end else begin
         state_ff      <= state_in;
         stage_idx_ff  <= stage_idx_in;
         pass_ff       <= pass_in;
         rsp_valid_ff  <= rsp_valid_in;
         ring_ff       <= ring_in;
         prev_final_ff <= prev_final_in;
         prev_input_ff <= prev_input_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      x_cur_ff    <= x_cur_in;
      acc_ff      <= acc_in;
      y_ff        <= y_in;
      rsp_data_ff <= rsp_data_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff     <= '0;
         gain_ff       <= llf_pkg::FEEDBACK_GAIN_RESET;
         fb_shift_ff   <= '0;
         oversample_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            llf_pkg::CSR_CUTOFF_COEFF:   cutoff_ff     <= csr_data[30:0];
            llf_pkg::CSR_FEEDBACK_GAIN:  gain_ff       <= csr_data[30:0];
            llf_pkg::CSR_FEEDBACK_SHIFT: fb_shift_ff   <= csr_data[3:0];
            llf_pkg::CSR_OVERSAMPLE_ON:  oversample_ff <= csr_data[0];
            default: begin
               oversample_ff <= oversample_ff;
            end
         endcase
      end
   end

endmodule

### sim/ladder_lowpass_filter_q31_unit_tb.sv
// Self-checking testbench for the four-pole ladder low-pass filter: random and directed samples.
`timescale 1ns / 100ps

module ladder_lowpass_filter_q31_unit_tb;

   localparam int RANDOM_ITEMS = 420;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_LIMIT = 10;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   llf_pkg::sample_type             req_sample_in = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   llf_pkg::sample_type             rsp_sample_out;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [llf_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [31:0]                     csr_data = '0;

   // samples waiting to be sent, filtered samples waiting to come back
   llf_pkg::sample_type sample_queue[$];
   llf_pkg::sample_type expected_samples[$];

   // filter state and register copies mirrored by the testbench
   llf_pkg::sample_type stage_q[4];
   llf_pkg::sample_type prev_last_stage;
   llf_pkg::sample_type prev_sample;
   llf_pkg::coeff_type  cutoff_reg;
   llf_pkg::coeff_type  gain_reg;
   logic [3:0]          fb_shift_reg;
   logic                oversample_reg;

   int sender_idle_pct = 29;
   int rsp_idle_pct    = 75;
   int mismatch_count  = 0;
   int quiet_cycles    = 0;
   llf_pkg::sample_type want_sample;

   ladder_lowpass_filter_q31_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #2 clock = ~clock;

   // saturating Q31 arithmetic
   function automatic llf_pkg::sample_type clamp_q31(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return llf_pkg::sample_type'(v[31:0]);
   endfunction

   function automatic llf_pkg::sample_type add_q31(input llf_pkg::sample_type a,
                                                   input llf_pkg::sample_type b);
      return clamp_q31(longint'(a) + longint'(b));
   endfunction

   function automatic llf_pkg::sample_type sub_q31(input llf_pkg::sample_type a,
                                                   input llf_pkg::sample_type b);
      return clamp_q31(longint'(a) - longint'(b));
   endfunction

   function automatic llf_pkg::sample_type halve_q31(input llf_pkg::sample_type a);
      return a >>> 1;
   endfunction

   function automatic llf_pkg::sample_type mul_q31(input llf_pkg::sample_type a,
                                                   input llf_pkg::sample_type b);
      longint prod;
      prod = longint'(a) * longint'(b);
      return clamp_q31(prod >>> 31);
   endfunction

   // feedback scaling by 2 - shift: left saturates, negative count goes right
   function automatic llf_pkg::sample_type scale_feedback(input llf_pkg::sample_type a,
                                                          input logic [3:0] sh);
      int n;
      n = 2 - int'(sh);
      if (n >= 0) return clamp_q31(longint'(a) <<< n);
      return a >>> (-n);
   endfunction

   // one pass through feedback and the four stages
   function automatic llf_pkg::sample_type ladder_update(input llf_pkg::sample_type x);
      llf_pkg::sample_type alpha;
      llf_pkg::sample_type gain;
      llf_pkg::sample_type fb;
      alpha = llf_pkg::sample_type'({1'b0, cutoff_reg});
      gain  = llf_pkg::sample_type'({1'b0, gain_reg});
      fb = add_q31(halve_q31(stage_q[3]), halve_q31(prev_last_stage));
      fb = scale_feedback(mul_q31(gain, fb), fb_shift_reg);
      stage_q[0] = add_q31(stage_q[0],
                           mul_q31(alpha, sub_q31(x, add_q31(fb, stage_q[0]))));
      prev_last_stage = stage_q[3];
      for (int i = 1; i < 4; i++) begin
         stage_q[i] = add_q31(stage_q[i], mul_q31(alpha, sub_q31(stage_q[i-1], stage_q[i])));
      end
      return stage_q[3];
   endfunction

   // filtered output for one input sample, oversampled when enabled
   function automatic llf_pkg::sample_type filter_sample(input llf_pkg::sample_type x);
      llf_pkg::sample_type mid;
      llf_pkg::sample_type y;
      if (oversample_reg) begin
         mid = add_q31(halve_q31(x), halve_q31(prev_sample));
         y = halve_q31(ladder_update(mid));
         y = add_q31(y, halve_q31(ladder_update(x)));
         prev_sample = x;
      end else begin
         y = ladder_update(x);
      end
      return y;
   endfunction

   task automatic log_mismatch(input string what, input llf_pkg::sample_type want_v,
                               input llf_pkg::sample_type got_v);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%s: expected %0d actual %0d", what, want_v, got_v);
      end
   endtask

   // register write, mirrored once the word is taken
   task automatic write_csr(input logic [llf_pkg::CsrIdxWidth-1:0] idx,
                            input logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         llf_pkg::CSR_CUTOFF_COEFF:   cutoff_reg     = data[30:0];
         llf_pkg::CSR_FEEDBACK_GAIN:  gain_reg       = data[30:0];
         llf_pkg::CSR_FEEDBACK_SHIFT: fb_shift_reg   = data[3:0];
         llf_pkg::CSR_OVERSAMPLE_ON:  oversample_reg = data[0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [31:0] cutoff, input logic [31:0] gain,
                            input logic [31:0] shift, input logic [31:0] os);
      write_csr(llf_pkg::CSR_CUTOFF_COEFF, cutoff);
      write_csr(llf_pkg::CSR_FEEDBACK_GAIN, gain);
      write_csr(llf_pkg::CSR_FEEDBACK_SHIFT, shift);
      write_csr(llf_pkg::CSR_OVERSAMPLE_ON, os);
   endtask

   // block until every queued sample has gone in and come back
   task automatic wait_idle();
      do @(posedge clock);
      while (sample_queue.size() != 0 || expected_samples.size() != 0 || req_valid);
   endtask

   task automatic send(input llf_pkg::sample_type s);
      sample_queue.push_back(s);
   endtask

   // coefficient mix: extremes, a masked top bit, typical small cutoffs, anything
   function automatic logic [31:0] pick_coeff();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3, 4, 5: return $urandom_range(32'h1000_0000);
         default: return $urandom;
      endcase
   endfunction

   // steps (held values), small signals, full-scale noise and the rails
   function automatic llf_pkg::sample_type next_sample(input llf_pkg::sample_type last);
      case ($urandom_range(9))
         0, 1, 2, 3: return llf_pkg::sample_type'($urandom);
         4, 5, 6:    return last;
         7, 8:       return llf_pkg::sample_type'($urandom) >>> 8;
         default:    return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      endcase
   endfunction

   // sample driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_samples.push_back(filter_sample(req_sample_in));
            void'(sample_queue.pop_front());
         end
         if (req_valid && !req_ready) begin
            // hold the word until taken
         end else if (sample_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid     <= 1'b1;
            req_sample_in <= sample_queue[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               log_mismatch("unexpected result", 'x, rsp_sample_out);
            end else begin
               want_sample = expected_samples.pop_front();
               if (rsp_sample_out !== want_sample) begin
                  log_mismatch("sample_out", want_sample, rsp_sample_out);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int n;
      int items_sent;
      llf_pkg::sample_type last;
      items_sent = 0;
      last = '0;
      for (int i = 0; i < 4; i++) stage_q[i] = '0;
      prev_last_stage = '0;
      prev_sample     = '0;
      cutoff_reg      = '0;
      gain_reg        = llf_pkg::FEEDBACK_GAIN_RESET;
      fb_shift_reg    = '0;
      oversample_reg  = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero cutoff holds the output at zero
      send(32'sh7FFF_FFFF);
      send(32'sh8000_0000);
      wait_idle();

      // widest cutoff and full gain, rails and values around zero
      write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0);
      repeat (3) send(32'sh7FFF_FFFF);
      repeat (3) send(32'sh8000_0000);
      send(32'sd0);
      send(-32'sd1);
      send(32'sd1);
      wait_idle();

      // shift count past two turns into a right shift; cutoff top bit is dropped
      write_csr(llf_pkg::CSR_FEEDBACK_SHIFT, 32'hFFFF_FFFF);
      write_csr(llf_pkg::CSR_CUTOFF_COEFF, 32'hFFFF_FFFF);
      send(32'sh7FFF_FFFF);
      send(32'sh8000_0000);
      send(32'sh1234_5678);
      wait_idle();

      // oversampling on, midpoint from zero history
      write_all(32'h2000_0000, 32'h4000_0000, 32'd3, 32'd1);
      send(32'sh7FFF_FFFF);
      send(32'sh8000_0000);
      send(-32'sd1);
      send(32'sh4000_0000);
      wait_idle();

      // oversampling off: previous input must stay frozen
      write_csr(llf_pkg::CSR_OVERSAMPLE_ON, 32'hFFFF_FFFE);
      write_csr(llf_pkg::CSR_CUTOFF_COEFF, 32'h8000_0000);
      send(32'sh7FFF_FFFF);
      send(32'sh5555_5555);
      wait_idle();

      // back on: first midpoint uses the stale stored input; zero gain
      write_all(32'h7FFF_FFFF, 32'h0000_0000, 32'd2, 32'h8000_0001);
      send(32'sd0);
      send(32'sh8000_0000);
      send(32'sh7FFF_FFFF);
      wait_idle();

      // random settings, each followed by a burst of samples
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= 2 * RANDOM_ITEMS / 3) begin
            sender_idle_pct = 0;
            rsp_idle_pct    = 0;
         end else if (items_sent >= RANDOM_ITEMS / 3) begin
            sender_idle_pct = 75;
            rsp_idle_pct    = 29;
         end
         if ($urandom_range(9) < 7) write_csr(llf_pkg::CSR_CUTOFF_COEFF, pick_coeff());
         if ($urandom_range(9) < 7) write_csr(llf_pkg::CSR_FEEDBACK_GAIN, pick_coeff());
         if ($urandom_range(9) < 7) write_csr(llf_pkg::CSR_FEEDBACK_SHIFT, $urandom);
         if ($urandom_range(9) < 5) write_csr(llf_pkg::CSR_OVERSAMPLE_ON, $urandom);
         n = $urandom_range(30, 8);
         repeat (n) begin
            last = next_sample(last);
            send(last);
         end
         items_sent += n;
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_samples.size() != 0) begin
         mismatch_count += expected_samples.size();
         $display("%0d results never arrived", expected_samples.size());
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### ladder_lowpass_filter_q31_unit.f
hw/rtl/llf_pkg.sv
hw/rtl/llf_qmul.sv
hw/rtl/ladder_lowpass_filter_q31_unit.sv
sim/ladder_lowpass_filter_q31_unit_tb.sv
